FILE: hw/rtl/urmf_pkg.sv
// Package for the ultrasonic range median filter.
// Holds the channel payload structs, configuration struct, register indexes and constants.
// No dependencies.
package urmf_pkg;

	// distance in 1/16 cm
	typedef logic [14:0] dist_t;

	// echo time to distance: (echo_us * SCALE_MUL) >> SCALE_SHIFT
	localparam int unsigned SCALE_MUL   = 4496;
	localparam int unsigned SCALE_SHIFT = 14;
	localparam int unsigned PROD_W      = 29;

	// sample value held by every ring entry after reset
	localparam dist_t FAR_RESET = 15'd6400;

	// configuration register indexes
	localparam logic [2:0] CFG_VALID_MIN        = 3'd0;
	localparam logic [2:0] CFG_VALID_MAX        = 3'd1;
	localparam logic [2:0] CFG_FAR_VALUE        = 3'd2;
	localparam logic [2:0] CFG_SPIKE_MEDIAN_MIN = 3'd3;
	localparam logic [2:0] CFG_SPIKE_NEW_MAX    = 3'd4;
	localparam logic [2:0] CFG_SPIKE_DROP_MIN   = 3'd5;
	localparam logic [2:0] CFG_WARN_LIMIT       = 3'd6;

	// configuration register file
	typedef struct packed {
		dist_t valid_min;
		dist_t valid_max;
		dist_t far_value;
		dist_t spike_median_min;
		dist_t spike_new_max;
		dist_t spike_drop_min;
		dist_t warn_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		valid_min:        15'd32,
		valid_max:        15'd7200,
		far_value:        15'd6400,
		spike_median_min: 15'd1600,
		spike_new_max:    15'd480,
		spike_drop_min:   15'd1920,
		warn_limit:       15'd800
	};

	// one echo reading
	typedef struct packed {
		logic        channel;
		logic [15:0] echo_us;
	} in_t;

	// one filter result
	typedef struct packed {
		dist_t front_median;
		logic  front_median_valid;
		dist_t rear_median;
		logic  rear_median_valid;
		dist_t nearest;
		dist_t farthest;
		logic  extremes_valid;
		logic  front_obstacle;
		logic  rear_obstacle;
		logic  any_obstacle;
		logic  sample_taken;
	} out_t;

endpackage

FILE: hw/rtl/urmf_scale.sv
// Echo time to distance conversion with window clamp.
// Combinational; uses urmf_pkg.
module urmf_scale (
	input  logic [15:0]    echo_us,
	input  urmf_pkg::cfg_t cfg,
	output urmf_pkg::dist_t distance
);
	import urmf_pkg::*;

	logic [PROD_W-1:0] prod;
	dist_t             raw;
	logic              out_of_window;

	// fixed point scale, result fits 15 bits for any 16 bit echo
	assign prod = PROD_W'(echo_us) * PROD_W'(SCALE_MUL);
	assign raw  = prod[SCALE_SHIFT +: 15];

	// missing echo or out of window reads as far value
	assign out_of_window = (echo_us == 16'd0) || (raw < cfg.valid_min) || (raw > cfg.valid_max);
	assign distance      = out_of_window ? cfg.far_value : raw;

endmodule

FILE: hw/rtl/urmf_median.sv
// Median of a set of distances by rank counting, one comparator row per entry.
// Combinational; uses urmf_pkg.
module urmf_median #(
	parameter int DEPTH = 5
) (
	input  urmf_pkg::dist_t [DEPTH-1:0] vals,
	output urmf_pkg::dist_t             med
);
	import urmf_pkg::*;

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int MID = DEPTH / 2;

	// rank of entry i: entries below it, ties broken by position
	always_comb begin
		logic [CW-1:0] cnt;
		med = '0;
		for (int i = 0; i < DEPTH; i++) begin
			cnt = '0;
			for (int j = 0; j < DEPTH; j++) begin
				if (j != i) begin
					if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
						cnt = cnt + CW'(1);
					end
				end
			end
			if (cnt == CW'(MID)) begin
				med = vals[i];
			end
		end
	end

endmodule

FILE: hw/rtl/urmf_ring.sv
// One channel's sample ring with spike rejection and a registered median.
// Uses urmf_pkg and urmf_median.
module urmf_ring #(
	parameter int DEPTH = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  urmf_pkg::dist_t distance,
	input  urmf_pkg::cfg_t  cfg,
	output logic            accept,
	output urmf_pkg::dist_t med,
	output logic            filled
);
	import urmf_pkg::*;

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	dist_t [DEPTH-1:0] samples_q;
	dist_t [DEPTH-1:0] samples_nxt;
	logic  [SW-1:0]    slot_q;
	logic              filled_q;
	dist_t             med_q;
	dist_t             med_nxt;
	logic              spike;
	logic              store;

	// spike test against the median of the current contents
	assign spike = filled_q && (med_q > cfg.spike_median_min) && (distance < cfg.spike_new_max)
		&& (med_q > distance) && ((med_q - distance) > cfg.spike_drop_min);
	assign accept = !spike;
	assign store  = wr && !spike;

	// contents after the write
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			samples_nxt[i] = (slot_q == SW'(i)) ? distance : samples_q[i];
		end
	end

	urmf_median #(.DEPTH(DEPTH)) u_median (
		.vals (samples_nxt),
		.med  (med_nxt)
	);

	// ring state, median kept in step with the contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= {DEPTH{FAR_RESET}};
			slot_q    <= '0;
			filled_q  <= 1'b0;
			med_q     <= FAR_RESET;
		end else if (store) begin
			samples_q <= samples_nxt;
			slot_q    <= (slot_q == SW'(DEPTH - 1)) ? '0 : slot_q + SW'(1);
			filled_q  <= 1'b1;
			med_q     <= med_nxt;
		end
	end

	assign med    = med_q;
	assign filled = filled_q;

endmodule

FILE: hw/rtl/ultrasonic_range_median_filter_top.sv
// Two-channel ultrasonic range filter with running median per channel.
// Uses urmf_pkg, urmf_scale, urmf_ring.
//
// Usage:
//   sample channel: sample_valid/sample_stall/sample carry one echo time and the
//   channel (front or rear). A transfer happens when valid is high and stall low.
//   result channel: result_valid/result_stall/result carry one result per reading:
//   both medians after the update, nearest/farthest, obstacle flags, sample_taken.
//   cfg_we/cfg_index/cfg_data write one 15-bit register per cycle; write only
//   while no reading is in flight. Indexes beyond the last register are ignored.
// Timing:
//   Four register stages: input, scaled distance, ring commit, result. A reading
//   passes through them in that order, and its result is then offered on the result
//   channel. One reading per cycle is taken while no stage is held; the ring commit
//   and median update happen in the same cycle.
//   A stalled result holds; stages behind it keep filling until all are full,
//   then sample_stall rises.
// Reset:
//   arst_n clears registers to defaults, rings to far distance, no pending items.
module ultrasonic_range_median_filter_top #(
	parameter int FILTER_DEPTH = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_stall,
	input  urmf_pkg::in_t   sample,
	output logic            result_valid,
	input  logic            result_stall,
	output urmf_pkg::out_t  result,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  urmf_pkg::dist_t cfg_data
);
	import urmf_pkg::*;

	cfg_t  cfg_q;
	in_t   in_s1;
	logic  v_s1;
	dist_t dist_s1;
	logic  ch_s2;
	dist_t dist_s2;
	logic  v_s2;
	logic  taken_s3;
	logic  v_s3;
	out_t  result_q;
	logic  result_valid_q;
	logic  rdy_out, rdy_s3, rdy_s2, rdy_s1;
	logic  commit;
	logic  acc_f, acc_r;
	logic  filled_f, filled_r;
	dist_t med_f, med_r;
	out_t  res_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VALID_MIN:        cfg_q.valid_min        <= cfg_data;
				CFG_VALID_MAX:        cfg_q.valid_max        <= cfg_data;
				CFG_FAR_VALUE:        cfg_q.far_value        <= cfg_data;
				CFG_SPIKE_MEDIAN_MIN: cfg_q.spike_median_min <= cfg_data;
				CFG_SPIKE_NEW_MAX:    cfg_q.spike_new_max    <= cfg_data;
				CFG_SPIKE_DROP_MIN:   cfg_q.spike_drop_min   <= cfg_data;
				CFG_WARN_LIMIT:       cfg_q.warn_limit       <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage readiness, each stage moves when the next one frees up
	assign rdy_out      = !result_valid_q || !result_stall;
	assign rdy_s3       = !v_s3 || rdy_out;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;
	assign commit       = v_s2 && rdy_s3;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample_valid) begin
			in_s1 <= sample;
		end
	end

	urmf_scale u_scale (
		.echo_us  (in_s1.echo_us),
		.cfg      (cfg_q),
		.distance (dist_s1)
	);

	// stage 2: scaled distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ch_s2   <= in_s1.channel;
			dist_s2 <= dist_s1;
		end
	end

	// per-channel rings, written on commit
	urmf_ring #(.DEPTH(FILTER_DEPTH)) u_ring_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (commit && !ch_s2),
		.distance (dist_s2),
		.cfg      (cfg_q),
		.accept   (acc_f),
		.med      (med_f),
		.filled   (filled_f)
	);

	urmf_ring #(.DEPTH(FILTER_DEPTH)) u_ring_rear (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (commit && ch_s2),
		.distance (dist_s2),
		.cfg      (cfg_q),
		.accept   (acc_r),
		.med      (med_r),
		.filled   (filled_r)
	);

	// stage 3: committed reading, medians now current
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			taken_s3 <= ch_s2 ? acc_r : acc_f;
		end
	end

	// result formatting from the ring medians
	always_comb begin
		dist_t fm;
		dist_t rm;
		fm = filled_f ? med_f : '0;
		rm = filled_r ? med_r : '0;
		res_nxt                    = '0;
		res_nxt.front_median       = fm;
		res_nxt.front_median_valid = filled_f;
		res_nxt.rear_median        = rm;
		res_nxt.rear_median_valid  = filled_r;
		res_nxt.extremes_valid     = filled_f || filled_r;
		if (filled_f && filled_r) begin
			res_nxt.nearest  = (fm < rm) ? fm : rm;
			res_nxt.farthest = (fm > rm) ? fm : rm;
		end else if (filled_f) begin
			res_nxt.nearest  = fm;
			res_nxt.farthest = fm;
		end else if (filled_r) begin
			res_nxt.nearest  = rm;
			res_nxt.farthest = rm;
		end
		res_nxt.front_obstacle = filled_f && (fm != '0) && (fm <= cfg_q.warn_limit);
		res_nxt.rear_obstacle  = filled_r && (rm != '0) && (rm <= cfg_q.warn_limit);
		res_nxt.any_obstacle   = res_nxt.front_obstacle || res_nxt.rear_obstacle;
		res_nxt.sample_taken   = taken_s3;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rdy_out) begin
			result_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for ultrasonic_range_median_filter_top: predicts each result from the readings
// accepted and checks the result stream field by field. Needs urmf_pkg and the filter RTL.
module tb_top;
	import urmf_pkg::*;

	localparam int RING_DEPTH = 5;
	// cycles with no transfer before the run is declared hung; set well above the slowest
	// legal stretch (long receiver hold plus a full register rewrite and drain)
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// four pipeline stages, plus margin
	localparam int DRAIN_CYCLES = 12;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned HOLD_CYCLES = 60;
	// unused register index, writes must be ignored
	localparam logic [2:0] CFG_SPARE = 3'd7;

	// Reference predictor of both rings plus the queue of results still owed
	class range_result_scoreboard;
		cfg_t regs;
		dist_t samples[2][RING_DEPTH];
		int unsigned next_slot[2];
		bit filled[2];
		out_t pending_results[$];
		int unsigned failures;
		int unsigned results_seen;

		function new();
			regs = CFG_RESET;
			for (int c = 0; c < 2; c++) begin
				for (int i = 0; i < RING_DEPTH; i++)
					samples[c][i] = FAR_RESET;
				next_slot[c] = 0;
				filled[c] = 1'b0;
			end
			failures = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [2:0] reg_index, dist_t value);
			case (reg_index)
				CFG_VALID_MIN:        regs.valid_min = value;
				CFG_VALID_MAX:        regs.valid_max = value;
				CFG_FAR_VALUE:        regs.far_value = value;
				CFG_SPIKE_MEDIAN_MIN: regs.spike_median_min = value;
				CFG_SPIKE_NEW_MAX:    regs.spike_new_max = value;
				CFG_SPIKE_DROP_MIN:   regs.spike_drop_min = value;
				CFG_WARN_LIMIT:       regs.warn_limit = value;
				default: ;
			endcase
		endfunction

		function dist_t ring_median(int ch);
			dist_t sorted[RING_DEPTH];
			dist_t swap;
			for (int i = 0; i < RING_DEPTH; i++)
				sorted[i] = samples[ch][i];
			for (int i = 0; i < RING_DEPTH - 1; i++)
				for (int j = i + 1; j < RING_DEPTH; j++)
					if (sorted[i] > sorted[j]) begin
						swap = sorted[i];
						sorted[i] = sorted[j];
						sorted[j] = swap;
					end
			return sorted[RING_DEPTH / 2];
		endfunction

		// Accepted reading: update the ring and queue the result it must produce
		function void predict_reading(in_t rd);
			logic [31:0] scaled;
			dist_t range_val, med, fm, rm;
			int ch;
			bit keep;
			out_t exp_res;
			ch = int'(rd.channel);
			scaled = (32'(rd.echo_us) * SCALE_MUL) >> SCALE_SHIFT;
			// missing echo or outside the window reads as far
			if (rd.echo_us == 16'd0 || scaled < regs.valid_min || scaled > regs.valid_max)
				range_val = regs.far_value;
			else
				range_val = scaled[14:0];
			// spike test only once the ring holds real data
			keep = 1'b1;
			if (filled[ch]) begin
				med = ring_median(ch);
				if (med > regs.spike_median_min && range_val < regs.spike_new_max &&
					med > range_val && (med - range_val) > regs.spike_drop_min)
					keep = 1'b0;
			end
			if (keep) begin
				samples[ch][next_slot[ch]] = range_val;
				next_slot[ch] = (next_slot[ch] + 1) % RING_DEPTH;
				filled[ch] = 1'b1;
			end
			fm = filled[0] ? ring_median(0) : '0;
			rm = filled[1] ? ring_median(1) : '0;
			exp_res = '0;
			exp_res.front_median = fm;
			exp_res.front_median_valid = filled[0];
			exp_res.rear_median = rm;
			exp_res.rear_median_valid = filled[1];
			if (filled[0] && filled[1]) begin
				exp_res.nearest = (fm < rm) ? fm : rm;
				exp_res.farthest = (fm > rm) ? fm : rm;
			end else if (filled[0]) begin
				exp_res.nearest = fm;
				exp_res.farthest = fm;
			end else if (filled[1]) begin
				exp_res.nearest = rm;
				exp_res.farthest = rm;
			end
			exp_res.extremes_valid = filled[0] || filled[1];
			exp_res.front_obstacle = filled[0] && fm != 0 && fm <= regs.warn_limit;
			exp_res.rear_obstacle = filled[1] && rm != 0 && rm <= regs.warn_limit;
			exp_res.any_obstacle = exp_res.front_obstacle || exp_res.rear_obstacle;
			exp_res.sample_taken = keep;
			pending_results.push_back(exp_res);
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("ERROR @%0t: %s", $time, msg);
		endfunction

		function void match_field(string field, logic [15:0] want, logic [15:0] got);
			if (got !== want)
				flag($sformatf("result %0d %s: expected %0d, got %0d", results_seen, field,
					want, got));
		endfunction

		function void check_result(out_t got);
			out_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				flag($sformatf("result %0d arrived with no reading outstanding", results_seen));
				return;
			end
			want = pending_results.pop_front();
			match_field("front_median", 16'(want.front_median), 16'(got.front_median));
			match_field("front_median_valid", 16'(want.front_median_valid),
				16'(got.front_median_valid));
			match_field("rear_median", 16'(want.rear_median), 16'(got.rear_median));
			match_field("rear_median_valid", 16'(want.rear_median_valid),
				16'(got.rear_median_valid));
			match_field("nearest", 16'(want.nearest), 16'(got.nearest));
			match_field("farthest", 16'(want.farthest), 16'(got.farthest));
			match_field("extremes_valid", 16'(want.extremes_valid), 16'(got.extremes_valid));
			match_field("front_obstacle", 16'(want.front_obstacle), 16'(got.front_obstacle));
			match_field("rear_obstacle", 16'(want.rear_obstacle), 16'(got.rear_obstacle));
			match_field("any_obstacle", 16'(want.any_obstacle), 16'(got.any_obstacle));
			match_field("sample_taken", 16'(want.sample_taken), 16'(got.sample_taken));
		endfunction

		function void close_out();
			if (pending_results.size() != 0)
				flag($sformatf("%0d results never arrived", pending_results.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid;
	logic sample_stall;
	in_t sample;
	logic result_valid;
	logic result_stall;
	out_t result;
	logic cfg_we;
	logic [2:0] cfg_index;
	dist_t cfg_data;

	range_result_scoreboard tracker;
	int unsigned quiet_cycles = 0;
	int unsigned hold_requests = 0;
	bit timed_out = 1'b0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;

	always #4 clk = ~clk;

	ultrasonic_range_median_filter_top #(
		.FILTER_DEPTH(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Monitor: note every transfer on both channels, track cycles without progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				tracker.predict_reading(sample);
			if (result_valid && !result_stall)
				tracker.check_result(result);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stalls between transfers, or one long hold when requested
	initial begin
		int unsigned n;
		int unsigned holds_served;
		result_stall = 1'b0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			if (hold_requests != holds_served) begin
				n = HOLD_CYCLES;
				holds_served = hold_requests;
			end else begin
				n = receiver_idles ? $urandom_range(0, 5) : 0;
			end
			if (n > 0) begin
				@(negedge clk) result_stall <= 1'b1;
				repeat (n) @(negedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	task automatic send_reading(bit ch, logic [15:0] echo);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			@(negedge clk) sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= '{channel: ch, echo_us: echo};
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic send_random();
		logic [15:0] echo;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			echo = 16'd0;
		else if (pick < 22)
			echo = 16'($urandom);
		else if (pick < 40)
			echo = 16'($urandom_range(1, 2000));       // short: spike / obstacle range
		else if (pick < 48)
			echo = 16'($urandom_range(100, 140));      // around default minimum
		else if (pick < 54)
			echo = 16'($urandom_range(26200, 26280));  // around default maximum
		else
			echo = 16'($urandom_range(2000, 26000));
		send_reading(1'($urandom_range(0, 1)), echo);
	endtask

	// Wait for every owed result, then let the pipeline go quiet
	task automatic settle();
		@(negedge clk) sample_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(logic [2:0] reg_index, dist_t value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_reg(reg_index, value);
	endtask

	task automatic apply_config(cfg_t c);
		put_reg(CFG_VALID_MIN, c.valid_min);
		put_reg(CFG_VALID_MAX, c.valid_max);
		put_reg(CFG_FAR_VALUE, c.far_value);
		put_reg(CFG_SPIKE_MEDIAN_MIN, c.spike_median_min);
		put_reg(CFG_SPIKE_NEW_MAX, c.spike_new_max);
		put_reg(CFG_SPIKE_DROP_MIN, c.spike_drop_min);
		put_reg(CFG_WARN_LIMIT, c.warn_limit);
		put_reg(CFG_SPARE, 15'($urandom_range(0, 32767)));
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	function automatic cfg_t random_config(bit wide);
		cfg_t c;
		if (wide) begin
			c.valid_min = 15'($urandom_range(0, 32767));
			c.valid_max = 15'($urandom_range(0, 32767));
			c.far_value = 15'($urandom_range(0, 32767));
			c.spike_median_min = 15'($urandom_range(0, 32767));
			c.spike_new_max = 15'($urandom_range(0, 32767));
			c.spike_drop_min = 15'($urandom_range(0, 32767));
			c.warn_limit = 15'($urandom_range(0, 32767));
		end else begin
			c.valid_min = 15'($urandom_range(0, 200));
			c.valid_max = 15'($urandom_range(3000, 18000));
			c.far_value = 15'($urandom_range(0, 32767));
			c.spike_median_min = 15'($urandom_range(0, 4000));
			c.spike_new_max = 15'($urandom_range(0, 2000));
			c.spike_drop_min = 15'($urandom_range(0, 4000));
			c.warn_limit = 15'($urandom_range(0, 4000));
		end
		return c;
	endfunction

	// One register setting: rewrite registers while idle, optionally fill the pipe
	// against a held result side, then random readings
	task automatic run_phase(cfg_t c, bit tx_idle, bit rx_idle, int unsigned count,
		bit squeeze);
		settle();
		apply_config(c);
		sender_idles = tx_idle;
		receiver_idles = rx_idle;
		if (squeeze) begin
			hold_requests++;
			sender_idles = 1'b0;
			repeat (24) send_random();
			sender_idles = tx_idle;
		end
		repeat (count) send_random();
	endtask

	initial begin
		cfg_t c;
		sample_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tracker = new();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		fork
			begin
				// directed readings under reset settings
				send_reading(1'b0, 16'd0);       // missing echo
				send_reading(1'b0, 16'hFFFF);    // longest echo, beyond window
				send_reading(1'b0, 16'd116);     // just below minimum distance
				send_reading(1'b0, 16'd117);     // at minimum distance
				send_reading(1'b0, 16'd26240);   // at maximum distance
				send_reading(1'b0, 16'd26244);   // just above maximum
				send_reading(1'b0, 16'd1);       // converts to zero
				send_reading(1'b0, 16'd365);     // deep drop from far median: spike
				send_reading(1'b0, 16'd1500);    // spike
				send_reading(1'b0, 16'd1760);    // just above spike new-value limit
				repeat (4) send_reading(1'b1, 16'd2000);  // rear obstacle
				send_reading(1'b1, 16'd550);
				send_reading(1'b1, 16'hAAAA);
				send_reading(1'b1, 16'h5555);
				repeat (3) send_reading(1'b1, 16'd2916);  // median right at warn limit
				send_reading(1'b1, 16'd2920);
				send_reading(1'b0, 16'd0);

				run_phase(CFG_RESET, 1'b1, 1'b1, 140, 1'b1);
				c = '0;
				run_phase(c, 1'b1, 1'b1, 165, 1'b0);
				c = '1;
				run_phase(c, 1'b1, 1'b1, 165, 1'b0);
				// window inverted: everything reads far
				c = CFG_RESET;
				c.valid_min = 15'd20000;
				c.valid_max = 15'd100;
				c.far_value = 15'($urandom_range(0, 32767));
				run_phase(c, 1'b1, 1'b1, 165, 1'b0);
				// rejection whenever the new reading is below the median
				c = '{valid_min: 15'd0, valid_max: 15'h7FFF, far_value: 15'd6400,
					spike_median_min: 15'd0, spike_new_max: 15'h7FFF,
					spike_drop_min: 15'd0, warn_limit: 15'd1600};
				run_phase(c, 1'b1, 1'b1, 165, 1'b0);
				run_phase(random_config(1'b0), 1'b0, 1'b0, 165, 1'b0);
				run_phase(random_config(1'b0), 1'b0, 1'b1, 165, 1'b1);
				run_phase(random_config(1'b1), 1'b1, 1'b0, 165, 1'b0);
				settle();
			end
			begin
				wait (quiet_cycles >= WATCHDOG_LIMIT);
				timed_out = 1'b1;
			end
		join_any
		disable fork;

		tracker.close_out();
		if (!timed_out && tracker.failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
